### src/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg - shared types and constants for the stable rank sorter
// Holds the store depth, field widths and the structs that run along the
// chain of sorter cells.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } cell_data_t;

  typedef struct packed {
    logic             ins;
    logic             shift;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

### src/stable_rank_sorter_top.sv
// ----------------------------------------------------------------------------
// stable_rank_sorter_top - stable ascending sort of one set of signed values
// Insertion into a chain of compare cells, then a shift-out drain.
// ----------------------------------------------------------------------------
// Input stream s_*: one signed 32-bit value per transfer, s_tlast closes the
// set. While loading, one transfer is taken every cycle: the value is
// compared with every stored value at once and slotted into the chain.
// Values beyond 64 per set are dropped and the set is marked overflowed.
// After the closing transfer the block stops taking input and drains the
// chain through an output register, one result per cycle, smallest first;
// equal values leave in arrival order. After the closing transfer the state
// register moves to drain, and the first result is loaded into the output
// register when it is free. The drain yields one result per stored value.
// m_tlast marks the last result of the set, m_tuser carries the overflow
// flag on every result of the set. A stalled receiver holds the output
// register and freezes the drain. New input is taken again as soon as the
// last result is in the output register. Reset empties the chain at once.
// ----------------------------------------------------------------------------
module stable_rank_sorter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,
  output logic        m_tuser    // [0] overflow
);

  localparam int N = srs_pkg::CAPACITY;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                     state, state_next;
  logic [srs_pkg::CNT_W-1:0]  count, count_next;
  logic                       dropped, dropped_next;
  logic                       full;
  logic                       accept;
  logic                       load_out;
  srs_pkg::cell_ctrl_t        ctrl;
  srs_pkg::cell_data_t        chain [N];
  logic [N-1:0]               gt;
  logic [N-1:0]               valid_vec;

  assign full     = (count == srs_pkg::CNT_W'(N));
  assign s_tready = (state == ST_LOAD);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (state == ST_DRAIN) && (!m_tvalid || m_tready);

  assign ctrl.ins   = accept && !full;
  assign ctrl.shift = load_out;
  assign ctrl.value = s_tdata;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      srs_pkg::cell_data_t left_d, right_d;
      logic                left_g;
      if (i == 0) begin : g_first
        assign left_d = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_d = chain[i-1];
        assign left_g = gt[i-1];
      end
      if (i == N - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_inner
        assign right_d = chain[i+1];
      end
      srs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .left_data  (left_d),
        .left_gt    (left_g),
        .right_data (right_d),
        .data       (chain[i]),
        .gt         (gt[i])
      );
      assign valid_vec[i] = chain[i].valid;
    end
  endgenerate

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    case (state)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            dropped_next = 1'b1;
          end else begin
            count_next = count + 1'b1;
          end
          if (s_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (load_out) begin
          count_next = count - 1'b1;
          if (count == srs_pkg::CNT_W'(1)) begin
            state_next   = ST_LOAD;
            dropped_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= chain[0].value;
      m_tlast <= (count == srs_pkg::CNT_W'(1));
      m_tuser <= dropped;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= srs_pkg::CNT_W'(N))
    else $error("store count beyond capacity");

  a_chain_fill: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("occupied cells disagree with store count");

  a_drain_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && m_tvalid && !m_tlast && chain[0].valid)
      |-> ($signed(chain[0].value) >= $signed(m_tdata)))
    else $error("drain not in ascending order");

  a_no_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (count != '0))
    else $error("drain with empty store");

endmodule

### src/srs_cell.sv
// ----------------------------------------------------------------------------
// srs_cell - one slot of the sorted chain
// Compares its value with the broadcast value; on insert it either keeps
// its value, takes its left neighbor's, or takes the new value. On drain it
// takes its right neighbor's value.
// ----------------------------------------------------------------------------
module srs_cell (
  input  logic               clk,
  input  logic               rst,
  input  srs_pkg::cell_ctrl_t ctrl,
  input  srs_pkg::cell_data_t left_data,
  input  logic               left_gt,
  input  srs_pkg::cell_data_t right_data,
  output srs_pkg::cell_data_t data,
  output logic               gt
);

  // empty slots rank above everything; equal values stay in front (stable)
  assign gt = !data.valid || ($signed(data.value) > $signed(ctrl.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
    end else if (ctrl.shift) begin
      data <= right_data;
    end else if (ctrl.ins && gt) begin
      if (left_gt) begin
        data <= left_data;
      end else begin
        data.valid <= 1'b1;
        data.value <= ctrl.value;
      end
    end
  end

endmodule
